// ----- src/ssob_pkg.sv -----
`timescale 1ns / 1ps
package ssob_pkg;

  // Input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_RANGE_GAIN      = 2'd0;
  localparam logic [1:0] CFG_BASE_PITCH      = 2'd1;
  localparam logic [1:0] CFG_DISTANCE_OFFSET = 2'd2;

  localparam logic [7:0]  RANGE_GAIN_RST      = 8'd3;
  localparam logic [14:0] BASE_PITCH_RST      = 15'd100;
  localparam logic [15:0] DISTANCE_OFFSET_RST = 16'd100;

  // Divider widths: dividend is c << 16 of the distance gain
  localparam int DVD_W = 32;
  localparam int DVS_W = 17;

  // Q30 polynomial coefficients of the sine approximation
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598666;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  localparam logic [14:0] MAG_MAX = 15'd32767;

endpackage

// ----- src/stereo_sine_oscillator_bank.sv -----
`timescale 1ns / 1ps
// Stereo sine oscillator bank. A load item (operation 0) computes pitch, left
// gain and right gain for one source and writes them to the source table,
// after one 32-step divide for the distance gain. A tick item (operation 1)
// reads the first section_count entries (at most MAX_SECTIONS) one at a time
// from the table RAM, reduces the phase and the table address by reciprocal
// multiplication on a shared 32x32 multiplier, evaluates the sine polynomial
// on the same multiplier, and returns one saturated stereo sample; it holds
// in its last state until the output register is free. Only one item is in
// work at a time; the result sits in an output register, so the next item is
// taken while it waits. Reading a source entry that was never loaded gives
// undefined output.
module stereo_sine_oscillator_bank #(
  parameter int MAX_SECTIONS = 16,
  parameter int TICK_RATE    = 44100,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [3:0]         section_index,
  input  logic [9:0]         pitch_code,
  input  logic [15:0]        distance_value,
  input  logic [15:0]        pan_position,
  input  logic [4:0]         section_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] left_sample,
  output logic signed [19:0] right_sample,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW    = MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
  localparam int ACC_W = 33 + CNT_W;
  localparam int ENT_W = 48;
  localparam int AD_W  = $clog2(SINE_ENTRIES);

  // Reciprocal of the tick rate; the estimate is exact or one low
  localparam int          RECIP_SH   = 31 + $clog2(TICK_RATE);
  localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SH) / 64'(TICK_RATE);
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];

  typedef enum logic [24:0] {
    S_IDLE = 25'd1 << 0,
    S_LDS  = 25'd1 << 1,
    S_LDW  = 25'd1 << 2,
    S_LML  = 25'd1 << 3,
    S_LMR  = 25'd1 << 4,
    S_LWR  = 25'd1 << 5,
    S_TRD  = 25'd1 << 6,
    S_TMN  = 25'd1 << 7,
    S_TV   = 25'd1 << 8,
    S_TQ   = 25'd1 << 9,
    S_TR   = 25'd1 << 10,
    S_TAV  = 25'd1 << 11,
    S_TAQ  = 25'd1 << 12,
    S_TAR  = 25'd1 << 13,
    S_TX2  = 25'd1 << 14,
    S_TH9  = 25'd1 << 15,
    S_TH7  = 25'd1 << 16,
    S_TH5  = 25'd1 << 17,
    S_TH3  = 25'd1 << 18,
    S_TS   = 25'd1 << 19,
    S_TMAG = 25'd1 << 20,
    S_TACL = 25'd1 << 21,
    S_TACR = 25'd1 << 22,
    S_TNXT = 25'd1 << 23,
    S_TOUT = 25'd1 << 24
  } state_t;

  state_t state;

  logic [7:0]  range_gain;
  logic [14:0] base_pitch;
  logic [15:0] distance_offset;
  logic [15:0] sample_counter;

  // Load operands
  logic [15:0]   ld_pitch;
  logic [15:0]   ld_c;
  logic [15:0]   ld_pan;
  logic [16:0]   ld_den;
  logic [15:0]   ld_gain;
  logic [15:0]   ld_left;
  logic [AW-1:0] ld_idx;

  // Tick operands
  logic [CNT_W-1:0] tk_count;
  logic [CNT_W-1:0] tk_j;
  logic [15:0]      e_lg;
  logic [15:0]      e_rg;
  logic [31:0]      v_reg;
  logic [31:0]      q_reg;
  logic [AD_W-1:0]  addr_reg;
  logic [31:0]      x_reg;
  logic [31:0]      x2_reg;
  logic [1:0]       quad;
  logic [14:0]      mag;
  logic signed [ACC_W-1:0] left_acc;
  logic signed [ACC_W-1:0] right_acc;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic                       div_start;
  logic [ssob_pkg::DVD_W-1:0] div_dvd;
  logic [ssob_pkg::DVS_W-1:0] div_dvs;
  logic                       div_busy;
  logic [ssob_pkg::DVD_W-1:0] div_quot;

  logic             ram_we;
  logic [ENT_W-1:0] ram_rdata;

  logic [18:0] pitch_raw;
  logic [6:0]  count_in;
  logic [CNT_W-1:0] count_clamped;
  logic [31:0] q_now;
  logic [32:0] red_r;
  logic        red_over;
  logic [15:0] phase_now;
  logic [31:0] addr_now;
  logic [29:0] p_val;
  logic [28:0] t_val;
  logic [31:0] x_now;
  logic [31:0] prod_q30;
  logic [63:0] mag_round;
  logic [14:0] mag_now;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-17:0] left_fl;
  logic signed [ACC_W-17:0] right_fl;
  logic signed [19:0] left_sat;
  logic signed [19:0] right_sat;

  assign in_ready = (state == S_IDLE);
  assign prod_q30 = prod[61:30];

  assign pitch_raw = 19'(pitch_code) * 19'(range_gain) + 19'(base_pitch);
  assign count_in  = 7'(section_count);
  assign count_clamped = (count_in > 7'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                      : CNT_W'(section_count);

  // Quotient estimate, then remainder with one correction step
  assign q_now     = 32'(prod >> RECIP_SH);
  assign red_r     = {1'b0, v_reg} - {1'b0, prod[31:0]};
  assign red_over  = (red_r >= 33'(TICK_RATE));
  assign phase_now = red_over ? 16'(red_r - 33'(TICK_RATE)) : red_r[15:0];
  assign addr_now  = q_reg + 32'(red_over);

  // Sine argument from p = addr * 2^30 / SINE_ENTRIES
  assign p_val = 30'(addr_reg) << (30 - AD_W);
  assign t_val = p_val[28] ? (29'h1000_0000 - 29'(p_val[27:0]))
                           : 29'(p_val[27:0]);
  assign x_now = {1'b0, t_val, 2'b00};

  assign mag_round = prod + 64'h2000_0000;
  assign mag_now   = (mag_round[63:30] > 34'(ssob_pkg::MAG_MAX))
                     ? ssob_pkg::MAG_MAX : mag_round[44:30];

  assign term = ACC_W'(prod[30:0]);

  // Floor to Q4.15, then saturate
  assign left_fl  = left_acc[ACC_W-1:16];
  assign right_fl = right_acc[ACC_W-1:16];

  always_comb begin
    if (left_fl > (ACC_W-16)'(524287)) begin
      left_sat = 20'sd524287;
    end else if (left_fl < -(ACC_W-16)'(524288)) begin
      left_sat = -20'sd524288;
    end else begin
      left_sat = left_fl[19:0];
    end
    if (right_fl > (ACC_W-16)'(524287)) begin
      right_sat = 20'sd524287;
    end else if (right_fl < -(ACC_W-16)'(524288)) begin
      right_sat = -20'sd524288;
    end else begin
      right_sat = right_fl[19:0];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LML: begin
        mul_a = 32'(ld_gain);
        mul_b = 32'(17'h10000 - 17'(ld_pan));
      end
      S_LMR: begin
        mul_a = 32'(ld_gain);
        mul_b = 32'(ld_pan);
      end
      S_TMN: begin
        mul_a = 32'(sample_counter);
        mul_b = 32'(ram_rdata[47:32]);
      end
      S_TV, S_TAV: begin
        mul_a = prod[31:0];
        mul_b = RECIP;
      end
      S_TQ, S_TAQ: begin
        mul_a = q_now;
        mul_b = 32'(TICK_RATE);
      end
      S_TR: begin
        mul_a = 32'(phase_now);
        mul_b = 32'(SINE_ENTRIES);
      end
      S_TX2: begin
        mul_a = x_now;
        mul_b = x_now;
      end
      S_TH9: begin
        mul_a = prod_q30;
        mul_b = ssob_pkg::SIN_C9;
      end
      S_TH7: begin
        mul_a = x2_reg;
        mul_b = ssob_pkg::SIN_C7 - prod_q30;
      end
      S_TH5: begin
        mul_a = x2_reg;
        mul_b = ssob_pkg::SIN_C5 - prod_q30;
      end
      S_TH3: begin
        mul_a = x2_reg;
        mul_b = ssob_pkg::SIN_C3 - prod_q30;
      end
      S_TS: begin
        mul_a = x_reg;
        mul_b = ssob_pkg::SIN_C1 - prod_q30;
      end
      S_TMAG: begin
        mul_a = prod_q30;
        mul_b = 32'(ssob_pkg::MAG_MAX);
      end
      S_TACL: begin
        mul_a = 32'(e_lg);
        mul_b = 32'(mag_now);
      end
      S_TACR: begin
        mul_a = 32'(e_rg);
        mul_b = 32'(mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider request for the distance gain
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state)
      S_LDS: begin
        div_start = 1'b1;
        div_dvd   = ssob_pkg::DVD_W'({ld_c, 16'h0000});
        div_dvs   = ld_den;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign ram_we = (state == S_LWR);

  ssob_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_quot)
  );

  ssob_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SECTIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_idx),
    .wdata ({ld_pitch, ld_left, prod[31:16]}),
    .raddr (tk_j[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      sample_counter  <= '0;
      range_gain      <= ssob_pkg::RANGE_GAIN_RST;
      base_pitch      <= ssob_pkg::BASE_PITCH_RST;
      distance_offset <= ssob_pkg::DISTANCE_OFFSET_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ssob_pkg::CFG_RANGE_GAIN:      range_gain      <= cfg_data[7:0];
          ssob_pkg::CFG_BASE_PITCH:      base_pitch      <= cfg_data[14:0];
          ssob_pkg::CFG_DISTANCE_OFFSET: distance_offset <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != S_TOUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation == ssob_pkg::OP_LOAD) begin
              // Drop loads beyond the table
              if (7'(section_index) < 7'(MAX_SECTIONS)) begin
                ld_idx   <= AW'(section_index);
                ld_pitch <= (pitch_raw > 19'hFFFF) ? 16'hFFFF : pitch_raw[15:0];
                ld_c     <= distance_value;
                ld_pan   <= pan_position;
                ld_den   <= 17'(distance_value) + 17'(distance_offset);
                state    <= S_LDS;
              end
            end else begin
              left_acc  <= '0;
              right_acc <= '0;
              tk_j      <= '0;
              tk_count  <= count_clamped;
              state     <= (count_clamped == '0) ? S_TOUT : S_TRD;
            end
          end
        end
        S_LDS: state <= S_LDW;
        S_LDW: begin
          if (!div_busy) begin
            if (ld_den == '0) begin
              ld_gain <= '0;
            end else if (div_quot > ssob_pkg::DVD_W'(16'hFFFF)) begin
              ld_gain <= 16'hFFFF;
            end else begin
              ld_gain <= div_quot[15:0];
            end
            state <= S_LML;
          end
        end
        S_LML: state <= S_LMR;
        S_LMR: begin
          ld_left <= prod[31:16];
          state   <= S_LWR;
        end
        S_LWR: state <= S_IDLE;
        S_TRD: state <= S_TMN;
        S_TMN: begin
          e_lg  <= ram_rdata[31:16];
          e_rg  <= ram_rdata[15:0];
          state <= S_TV;
        end
        S_TV: begin
          v_reg <= prod[31:0];
          state <= S_TQ;
        end
        S_TQ: state <= S_TR;
        S_TR: state <= S_TAV;
        S_TAV: begin
          v_reg <= prod[31:0];
          state <= S_TAQ;
        end
        S_TAQ: begin
          q_reg <= q_now;
          state <= S_TAR;
        end
        S_TAR: begin
          addr_reg <= (addr_now >= 32'(SINE_ENTRIES)) ? AD_W'(SINE_ENTRIES - 1)
                                                      : addr_now[AD_W-1:0];
          state    <= S_TX2;
        end
        S_TX2: begin
          x_reg <= x_now;
          quad  <= p_val[29:28];
          state <= S_TH9;
        end
        S_TH9: begin
          x2_reg <= prod_q30;
          state  <= S_TH7;
        end
        S_TH7:  state <= S_TH5;
        S_TH5:  state <= S_TH3;
        S_TH3:  state <= S_TS;
        S_TS:   state <= S_TMAG;
        S_TMAG: state <= S_TACL;
        S_TACL: begin
          mag   <= mag_now;
          state <= S_TACR;
        end
        S_TACR: begin
          left_acc <= quad[1] ? left_acc - term : left_acc + term;
          state    <= S_TNXT;
        end
        S_TNXT: begin
          right_acc <= quad[1] ? right_acc - term : right_acc + term;
          tk_j      <= tk_j + 1'b1;
          state     <= (tk_j + 1'b1 == tk_count) ? S_TOUT : S_TRD;
        end
        S_TOUT: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            left_sample  <= left_sat;
            right_sample <= right_sat;
            out_valid    <= 1'b1;
            sample_counter <= (sample_counter == 16'(TICK_RATE - 1))
                              ? '0 : sample_counter + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ssob_ram.sv -----
`timescale 1ns / 1ps
module ssob_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ssob_div.sv -----
`timescale 1ns / 1ps
module ssob_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ssob_pkg::DVD_W-1:0]   dividend,
  input  logic [ssob_pkg::DVS_W-1:0]   divisor,
  output logic                         busy,
  output logic [ssob_pkg::DVD_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(ssob_pkg::DVD_W + 1);

  logic [ssob_pkg::DVS_W-1:0] dvs;
  logic [ssob_pkg::DVS_W-1:0] rem;
  logic [STEP_W-1:0]          steps;
  logic [ssob_pkg::DVS_W:0]   trial;

  // One quotient bit per cycle, restoring
  assign trial = {rem, quotient[ssob_pkg::DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      steps    <= STEP_W'(ssob_pkg::DVD_W);
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= ssob_pkg::DVS_W'(trial - {1'b0, dvs});
        quotient <= {quotient[ssob_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem      <= trial[ssob_pkg::DVS_W-1:0];
        quotient <= {quotient[ssob_pkg::DVD_W-2:0], 1'b0};
      end
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
